>>> sv/fdcrc_pkg.sv
`default_nettype none
package fdcrc_pkg;

  localparam int unsigned POS_W = 17;

  localparam logic [POS_W-1:0] HDR_BYTES   = 17'd12;
  localparam logic [POS_W-1:0] TRAIL_BYTES = 17'd2;
  localparam logic [POS_W-1:0] MIN_BYTES   = HDR_BYTES + TRAIL_BYTES;
  localparam logic [POS_W-1:0] POS_MAX     = 17'd131071;

  localparam logic [3:0] OFS_MAGIC0  = 4'd0;
  localparam logic [3:0] OFS_MAGIC1  = 4'd1;
  localparam logic [3:0] OFS_VERSION = 4'd2;
  localparam logic [3:0] OFS_CLASS   = 4'd3;
  localparam logic [3:0] OFS_ID      = 4'd4;
  localparam logic [3:0] OFS_FLAGS   = 4'd5;
  localparam logic [3:0] OFS_SEQ0    = 4'd6;
  localparam logic [3:0] OFS_SEQ1    = 4'd7;
  localparam logic [3:0] OFS_SEQ2    = 4'd8;
  localparam logic [3:0] OFS_SEQ3    = 4'd9;
  localparam logic [3:0] OFS_LEN0    = 4'd10;
  localparam logic [3:0] OFS_LEN1    = 4'd11;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_BAD_HDR   = 3'd2;
  localparam logic [2:0] ST_LEN_MISM  = 3'd3;
  localparam logic [2:0] ST_CRC_MISM  = 3'd4;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  localparam int unsigned ADDR_W = 4;
  localparam logic [1:0] REG_MAGIC_FIRST  = 2'd0;
  localparam logic [1:0] REG_MAGIC_SECOND = 2'd1;
  localparam logic [1:0] REG_PROTO_VER    = 2'd2;
  localparam logic [1:0] REG_MAX_PAYLOAD  = 2'd3;

  localparam logic [15:0] MAX_PAYLOAD_RST = 16'd1024;
  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [15:0] CRC_POLY        = 16'h1021;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic [2:0]  frame_status;
    logic [7:0]  message_class;
    logic [7:0]  message_id;
    logic [7:0]  frame_flags;
    logic [31:0] sequence_number;
    logic [15:0] payload_length;
    logic [15:0] received_crc;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  magic_first;
    logic [7:0]  magic_second;
    logic [7:0]  protocol_version;
    logic [15:0] max_payload;
  } cfg_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

>>> sv/fdcrc_cfg.sv
`default_nettype none
module fdcrc_cfg
  import fdcrc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  cfg_t        cfg_r;
  logic [1:0]  reg_idx;
  logic        wr_en;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.magic_first      <= 8'd0;
      cfg_r.magic_second     <= 8'd0;
      cfg_r.protocol_version <= 8'd0;
      cfg_r.max_payload      <= MAX_PAYLOAD_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_MAGIC_FIRST:  cfg_r.magic_first      <= pwdata[7:0];
        REG_MAGIC_SECOND: cfg_r.magic_second     <= pwdata[7:0];
        REG_PROTO_VER:    cfg_r.protocol_version <= pwdata[7:0];
        REG_MAX_PAYLOAD:  cfg_r.max_payload      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MAGIC_FIRST:  prdata = {24'd0, cfg_r.magic_first};
      REG_MAGIC_SECOND: prdata = {24'd0, cfg_r.magic_second};
      REG_PROTO_VER:    prdata = {24'd0, cfg_r.protocol_version};
      REG_MAX_PAYLOAD:  prdata = {16'd0, cfg_r.max_payload};
      default:          prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

>>> sv/frame_deframer_crc16_check.sv
`default_nettype none
// Byte-serial frame deframer with CRC-16/CCITT-FALSE check. One byte per
// transaction enters an input register; header parsing, the byte-wide CRC
// update and the position compare run combinationally from it into the
// result register, so a byte can be taken every cycle while no result
// waits on out_stall. A payload byte not flagged last gives one result
// with its index; the byte flagged last gives one status result with the
// header fields and clears the frame state. Header and trailer bytes give
// no result. The output register and the input register stall together
// only while a result waits on out_stall.
module frame_deframer_crc16_check
  import fdcrc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire in_item_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output out_item_t              out_data,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready
);

  cfg_t cfg;

  fdcrc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  logic        in_vld_r;
  in_item_t    in_item_r;
  logic        out_vld_r;
  out_item_t   out_r;

  logic [POS_W-1:0] pos_r,     pos_nxt;
  logic             hdr_good_r, hdr_good_nxt;
  logic [7:0]       class_r,   class_nxt;
  logic [7:0]       id_r,      id_nxt;
  logic [7:0]       flags_r,   flags_nxt;
  logic [31:0]      seq_r,     seq_nxt;
  logic [15:0]      len_r,     len_nxt;
  logic [15:0]      crc_r,     crc_nxt;
  logic [15:0]      trl_r,     trl_nxt;

  logic             advance;
  logic             fire;
  logic             has_res;
  out_item_t        res;
  logic [POS_W-1:0] pay_end;
  logic [POS_W-1:0] pay_idx;
  logic [15:0]      crc_upd;
  logic [15:0]      len_full;
  logic [7:0]       b;
  logic             last;
  logic [2:0]       status;

  assign advance   = !out_vld_r || !out_stall;
  assign fire      = in_vld_r && advance;
  assign in_stall  = in_vld_r && !advance;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  assign b        = in_item_r.data_byte;
  assign last     = in_item_r.last_byte;
  assign pay_end  = HDR_BYTES + {1'b0, len_r};
  assign pay_idx  = pos_r - HDR_BYTES;
  assign crc_upd  = crc16_byte(crc_r, b);
  assign len_full = {b, len_r[7:0]};

  always_comb begin
    pos_nxt      = pos_r;
    hdr_good_nxt = hdr_good_r;
    class_nxt    = class_r;
    id_nxt       = id_r;
    flags_nxt    = flags_r;
    seq_nxt      = seq_r;
    len_nxt      = len_r;
    crc_nxt      = crc_r;
    trl_nxt      = trl_r;
    has_res      = 1'b0;
    status       = ST_OK;
    res          = '0;

    if (pos_r < HDR_BYTES) begin
      crc_nxt = crc_upd;
      case (pos_r[3:0])
        OFS_MAGIC0:  if (b != cfg.magic_first) hdr_good_nxt = 1'b0;
        OFS_MAGIC1:  if (b != cfg.magic_second) hdr_good_nxt = 1'b0;
        OFS_VERSION: if (b != cfg.protocol_version) hdr_good_nxt = 1'b0;
        OFS_CLASS:   class_nxt = b;
        OFS_ID:      id_nxt = b;
        OFS_FLAGS:   flags_nxt = b;
        OFS_SEQ0:    seq_nxt[7:0] = b;
        OFS_SEQ1:    seq_nxt[15:8] = b;
        OFS_SEQ2:    seq_nxt[23:16] = b;
        OFS_SEQ3:    seq_nxt[31:24] = b;
        OFS_LEN0:    len_nxt[7:0] = b;
        OFS_LEN1: begin
          len_nxt[15:8] = b;
          if (len_full > cfg.max_payload) hdr_good_nxt = 1'b0;
        end
        default: ;
      endcase
    end else if (pos_r < pay_end) begin
      crc_nxt = crc_upd;
      if (!last) begin
        has_res           = 1'b1;
        res.result_kind   = KIND_PAYLOAD;
        res.payload_byte  = b;
        res.payload_index = pay_idx[15:0];
      end
    end else if (pos_r == pay_end) begin
      trl_nxt[7:0] = b;
    end else if (pos_r == pay_end + 17'd1) begin
      trl_nxt[15:8] = b;
    end

    if (pos_r != POS_MAX) pos_nxt = pos_r + 17'd1;

    if (last) begin
      if (pos_nxt < MIN_BYTES) begin
        status = ST_SHORT;
      end else if (!hdr_good_nxt) begin
        status = ST_BAD_HDR;
      end else if (pos_nxt != pay_end + TRAIL_BYTES) begin
        status = ST_LEN_MISM;
      end else if (crc_nxt != trl_nxt) begin
        status = ST_CRC_MISM;
      end else begin
        status = ST_OK;
      end
      has_res             = 1'b1;
      res                 = '0;
      res.result_kind     = KIND_STATUS;
      res.frame_status    = status;
      res.message_class   = class_nxt;
      res.message_id      = id_nxt;
      res.frame_flags     = flags_nxt;
      res.sequence_number = seq_nxt;
      res.payload_length  = len_nxt;
      res.received_crc    = trl_nxt;

      pos_nxt      = '0;
      hdr_good_nxt = 1'b1;
      class_nxt    = 8'd0;
      id_nxt       = 8'd0;
      flags_nxt    = 8'd0;
      seq_nxt      = 32'd0;
      len_nxt      = 16'd0;
      crc_nxt      = CRC_INIT;
      trl_nxt      = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
      pos_r      <= '0;
      hdr_good_r <= 1'b1;
      class_r    <= 8'd0;
      id_r       <= 8'd0;
      flags_r    <= 8'd0;
      seq_r      <= 32'd0;
      len_r      <= 16'd0;
      crc_r      <= CRC_INIT;
      trl_r      <= 16'd0;
    end else begin
      if (!in_stall) in_vld_r <= in_valid;
      if (advance) out_vld_r <= fire && has_res;
      if (fire) begin
        pos_r      <= pos_nxt;
        hdr_good_r <= hdr_good_nxt;
        class_r    <= class_nxt;
        id_r       <= id_nxt;
        flags_r    <= flags_nxt;
        seq_r      <= seq_nxt;
        len_r      <= len_nxt;
        crc_r      <= crc_nxt;
        trl_r      <= trl_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) in_item_r <= in_data;
    if (fire && has_res) out_r <= res;
  end

endmodule
`default_nettype wire

>>> tb/sv/tb_frame_deframer_crc16_check.sv
`timescale 1ns / 100ps
module tb_frame_deframer_crc16_check;
  import fdcrc_pkg::*;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  in_item_t          in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_item_t         out_data;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  frame_deframer_crc16_check dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // register copies
  logic [7:0]  want_magic0 = 8'h00;
  logic [7:0]  want_magic1 = 8'h00;
  logic [7:0]  want_version = 8'h00;
  logic [15:0] want_max_len = MAX_PAYLOAD_RST;

  // frame parser state
  logic [16:0] frame_pos;
  logic        frame_hdr_ok;
  logic [7:0]  cap_class;
  logic [7:0]  cap_id;
  logic [7:0]  cap_flags;
  logic [31:0] cap_seq;
  logic [15:0] cap_len;
  logic [15:0] crc_acc;
  logic [15:0] crc_trailer;

  in_item_t  pending_bytes[$];
  out_item_t expected_results[$];
  int        mismatch_count = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  bit        hold_sender = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("frame_deframer_crc16_check verification failed");
    $finish;
  end

  function automatic logic [15:0] crc_ccitt_step(input logic [15:0] crc,
                                                 input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int k = 7; k >= 0; k--) begin
      fb = c[15] ^ b[k];
      c = {c[14:0], 1'b0} ^ (fb ? 16'h1021 : 16'h0000);
    end
    return c;
  endfunction

  task automatic clear_frame();
    frame_pos = '0;
    frame_hdr_ok = 1'b1;
    cap_class = '0;
    cap_id = '0;
    cap_flags = '0;
    cap_seq = '0;
    cap_len = '0;
    crc_acc = 16'hFFFF;
    crc_trailer = '0;
  endtask

  initial clear_frame();

  task automatic deframe_byte(input in_item_t it);
    logic [16:0] pos;
    logic [16:0] pay_end;
    logic [16:0] ofs;
    out_item_t   r;
    pos = frame_pos;
    pay_end = HDR_BYTES + {1'b0, cap_len};
    if (pos < HDR_BYTES) begin
      crc_acc = crc_ccitt_step(crc_acc, it.data_byte);
      case (pos[3:0])
        OFS_MAGIC0:  if (it.data_byte != want_magic0) frame_hdr_ok = 1'b0;
        OFS_MAGIC1:  if (it.data_byte != want_magic1) frame_hdr_ok = 1'b0;
        OFS_VERSION: if (it.data_byte != want_version) frame_hdr_ok = 1'b0;
        OFS_CLASS:   cap_class = it.data_byte;
        OFS_ID:      cap_id = it.data_byte;
        OFS_FLAGS:   cap_flags = it.data_byte;
        OFS_SEQ0:    cap_seq[7:0] = it.data_byte;
        OFS_SEQ1:    cap_seq[15:8] = it.data_byte;
        OFS_SEQ2:    cap_seq[23:16] = it.data_byte;
        OFS_SEQ3:    cap_seq[31:24] = it.data_byte;
        OFS_LEN0:    cap_len[7:0] = it.data_byte;
        OFS_LEN1: begin
          cap_len[15:8] = it.data_byte;
          if (cap_len > want_max_len) frame_hdr_ok = 1'b0;
        end
        default: ;
      endcase
    end else if (pos < pay_end) begin
      crc_acc = crc_ccitt_step(crc_acc, it.data_byte);
      if (!it.last_byte) begin
        ofs = pos - HDR_BYTES;
        r = '0;
        r.result_kind = KIND_PAYLOAD;
        r.payload_byte = it.data_byte;
        r.payload_index = ofs[15:0];
        expected_results.push_back(r);
      end
    end else if (pos == pay_end) begin
      crc_trailer[7:0] = it.data_byte;
    end else if (pos == pay_end + 17'd1) begin
      crc_trailer[15:8] = it.data_byte;
    end
    if (pos < POS_MAX) frame_pos = pos + 17'd1;
    if (it.last_byte) begin
      r = '0;
      r.result_kind = KIND_STATUS;
      if (frame_pos < MIN_BYTES) r.frame_status = ST_SHORT;
      else if (!frame_hdr_ok) r.frame_status = ST_BAD_HDR;
      else if (frame_pos != pay_end + TRAIL_BYTES) r.frame_status = ST_LEN_MISM;
      else if (crc_acc != crc_trailer) r.frame_status = ST_CRC_MISM;
      else r.frame_status = ST_OK;
      r.message_class = cap_class;
      r.message_id = cap_id;
      r.frame_flags = cap_flags;
      r.sequence_number = cap_seq;
      r.payload_length = cap_len;
      r.received_crc = crc_trailer;
      expected_results.push_back(r);
      clear_frame();
    end
  endtask

  task automatic report(input string field, input logic [31:0] exp_v,
                        input logic [31:0] act_v);
    if (mismatch_count < 40) begin
      $error("%s: expected %0h, actual %0h", field, exp_v, act_v);
    end
    mismatch_count++;
  endtask

  task automatic check_result(input out_item_t got, input out_item_t want);
    if (got.result_kind !== want.result_kind)
      report("result_kind", 32'(want.result_kind), 32'(got.result_kind));
    if (got.payload_byte !== want.payload_byte)
      report("payload_byte", 32'(want.payload_byte), 32'(got.payload_byte));
    if (got.payload_index !== want.payload_index)
      report("payload_index", 32'(want.payload_index), 32'(got.payload_index));
    if (got.frame_status !== want.frame_status)
      report("frame_status", 32'(want.frame_status), 32'(got.frame_status));
    if (got.message_class !== want.message_class)
      report("message_class", 32'(want.message_class), 32'(got.message_class));
    if (got.message_id !== want.message_id)
      report("message_id", 32'(want.message_id), 32'(got.message_id));
    if (got.frame_flags !== want.frame_flags)
      report("frame_flags", 32'(want.frame_flags), 32'(got.frame_flags));
    if (got.sequence_number !== want.sequence_number)
      report("sequence_number", want.sequence_number, got.sequence_number);
    if (got.payload_length !== want.payload_length)
      report("payload_length", 32'(want.payload_length), 32'(got.payload_length));
    if (got.received_crc !== want.received_crc)
      report("received_crc", 32'(want.received_crc), 32'(got.received_crc));
  endtask

  always @(posedge clk) begin : byte_driver
    bit took;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      took = in_valid && !in_stall;
      if (took) deframe_byte(in_data);
      if (!in_valid || took) begin
        if (pending_bytes.size() != 0 && !hold_sender &&
            $urandom_range(99) >= send_idle_pct) begin
          in_data <= pending_bytes.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    out_item_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          if (mismatch_count < 40) $error("result with none expected: %h", out_data);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          check_result(out_data, want);
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_MAGIC_FIRST:  want_magic0 = value[7:0];
      REG_MAGIC_SECOND: want_magic1 = value[7:0];
      REG_PROTO_VER:    want_version = value[7:0];
      REG_MAX_PAYLOAD:  want_max_len = value[15:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [7:0] m0, input logic [7:0] m1,
                            input logic [7:0] ver, input logic [15:0] max_len);
    write_reg(REG_MAGIC_FIRST, {24'd0, m0});
    write_reg(REG_MAGIC_SECOND, {24'd0, m1});
    write_reg(REG_PROTO_VER, {24'd0, ver});
    write_reg(REG_MAX_PAYLOAD, {16'd0, max_len});
  endtask

  task automatic drain_block();
    while (pending_bytes.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // trim drops bytes from the end, extra appends junk after the trailer
  task automatic queue_frame(input logic [7:0] m0, input logic [7:0] m1,
                             input logic [7:0] ver, input logic [7:0] cls,
                             input logic [7:0] id, input logic [7:0] flg,
                             input logic [31:0] seq, input logic [15:0] len_f,
                             input int n_pay, input bit bad_crc, input int trim,
                             input int extra, output int n);
    logic [7:0] fb[$];
    logic [7:0] hdr[12];
    logic [15:0] c;
    in_item_t it;
    hdr = '{m0, m1, ver, cls, id, flg, seq[7:0], seq[15:8], seq[23:16],
            seq[31:24], len_f[7:0], len_f[15:8]};
    foreach (hdr[i]) fb.push_back(hdr[i]);
    repeat (n_pay) fb.push_back(8'($urandom));
    c = 16'hFFFF;
    foreach (fb[i]) c = crc_ccitt_step(c, fb[i]);
    if (bad_crc) c = c ^ (16'h0001 << $urandom_range(15));
    fb.push_back(c[7:0]);
    fb.push_back(c[15:8]);
    repeat (extra) fb.push_back(8'($urandom));
    while (trim > 0 && fb.size() > 1) begin
      void'(fb.pop_back());
      trim--;
    end
    foreach (fb[i]) begin
      it.data_byte = fb[i];
      it.last_byte = (i == fb.size() - 1);
      pending_bytes.push_back(it);
    end
    n = fb.size();
  endtask

  task automatic queue_random_frame(output int n);
    int pick;
    int len_f;
    int n_pay;
    int trim;
    int extra;
    int lim;
    logic [7:0] m0;
    logic [7:0] m1;
    logic [7:0] ver;
    in_item_t it;
    m0 = want_magic0;
    m1 = want_magic1;
    ver = want_version;
    lim = (want_max_len < 12) ? want_max_len : 12;
    len_f = $urandom_range(0, lim);
    n_pay = len_f;
    trim = 0;
    extra = 0;
    pick = $urandom_range(99);
    if (pick < 65) begin
    end else if (pick < 69) begin
      m0 = 8'($urandom);
    end else if (pick < 73) begin
      m1 = 8'($urandom);
    end else if (pick < 77) begin
      ver = 8'($urandom);
    end else if (pick < 82) begin
      if (want_max_len != 16'hFFFF) begin
        len_f = int'(want_max_len) + 1 + $urandom_range(0, 3);
        if (len_f > 65535) len_f = 65535;
        n_pay = $urandom_range(0, 6);
      end
    end else if (pick < 87) begin
      n_pay = $urandom_range(0, 15);
    end else if (pick < 91) begin
      extra = $urandom_range(1, 4);
    end else if (pick < 96) begin
      trim = $urandom_range(1, 13 + n_pay);
    end else begin
      n = $urandom_range(1, 20);
      for (int i = 0; i < n; i++) begin
        it.data_byte = 8'($urandom);
        it.last_byte = (i == n - 1);
        pending_bytes.push_back(it);
      end
      return;
    end
    queue_frame(m0, m1, ver, 8'($urandom), 8'($urandom), 8'($urandom), $urandom,
                16'(len_f), n_pay, ($urandom_range(99) < 12), trim, extra, n);
  endtask

  initial begin : stimulus
    int n;
    int phase_items;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset register values, no idling
    queue_frame(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 32'h0, 16'd0, 0, 0, 0, 0, n);
    queue_frame(8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 16'd3, 3, 0, 0,
                0, n);
    queue_frame(8'h00, 8'h00, 8'h00, 8'h11, 8'h22, 8'h33, 32'h1, 16'd0, 0, 0, 13, 0, n);
    queue_frame(8'h00, 8'h00, 8'h00, 8'h44, 8'h55, 8'h66, 32'h2, 16'd0, 0, 0, 1, 0, n);
    queue_frame(8'h00, 8'h00, 8'h00, 8'h77, 8'h88, 8'h99, 32'h3, 16'd2, 2, 0, 10, 0, n);
    queue_frame(8'h80, 8'h00, 8'h00, 8'h01, 8'h02, 8'h03, 32'h4, 16'd2, 2, 0, 0, 0, n);
    queue_frame(8'h00, 8'h01, 8'h00, 8'h04, 8'h05, 8'h06, 32'h5, 16'd1, 1, 0, 0, 0, n);
    queue_frame(8'h00, 8'h00, 8'hFF, 8'h07, 8'h08, 8'h09, 32'h6, 16'd2, 2, 0, 0, 0, n);
    queue_frame(8'h00, 8'h00, 8'h00, 8'h0A, 8'h0B, 8'h0C, 32'h7, 16'd1025, 3, 0, 0, 0, n);
    queue_frame(8'h00, 8'h00, 8'h00, 8'h0D, 8'h0E, 8'h0F, 32'h8, 16'd5, 2, 0, 0, 0, n);
    queue_frame(8'h00, 8'h00, 8'h00, 8'h10, 8'h20, 8'h30, 32'h9, 16'd2, 4, 0, 0, 0, n);
    queue_frame(8'h00, 8'h00, 8'h00, 8'h40, 8'h50, 8'h60, 32'hA, 16'd1, 1, 0, 0, 3, n);
    queue_frame(8'h00, 8'h00, 8'h00, 8'h70, 8'h80, 8'h90, 32'hB, 16'd4, 4, 1, 0, 0, n);
    queue_frame(8'h00, 8'h00, 8'h00, 8'h5A, 8'hA5, 8'h3C, 32'h1234_5678, 16'd0, 0, 1, 0,
                0, n);
    drain_block();

    // widest declared length
    set_config(8'hA5, 8'h5A, 8'h01, 16'hFFFF);
    queue_frame(8'hA5, 8'h5A, 8'h01, 8'hC3, 8'h3C, 8'h81, 32'h8000_0001, 16'hFFFF, 4,
                0, 0, 0, n);
    queue_frame(8'hA5, 8'h5A, 8'h01, 8'h08, 8'h10, 8'h20, 32'h40, 16'd2, 2, 0, 0, 0, n);
    drain_block();

    for (int sub = 0; sub < 8; sub++) begin
      case (sub / 2)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      case (sub)
        0: set_config(8'h00, 8'h00, 8'h00, 16'd1024);
        1: set_config(8'hFF, 8'hFF, 8'hFF, 16'd0);
        3: set_config(8'h55, 8'hAA, 8'h80, 16'd8);
        4: set_config(8'($urandom), 8'($urandom), 8'($urandom), 16'hFFFF);
        7: set_config(8'h01, 8'h02, 8'h03, 16'd12);
        default: set_config(8'($urandom), 8'($urandom), 8'($urandom),
                            16'($urandom_range(0, 20)));
      endcase
      phase_items = 0;
      while (phase_items < 85) begin
        queue_random_frame(n);
        phase_items += n;
      end
      if (sub == 2) begin
        while (pending_bytes.size() > phase_items / 2) @(posedge clk);
        hold_sender = 1'b1;
        while (in_valid || expected_results.size() != 0) @(posedge clk);
        hold_sender = 1'b0;
      end
      drain_block();
    end

    if (mismatch_count == 0) begin
      $display("frame_deframer_crc16_check verification clean");
    end else begin
      $display("frame_deframer_crc16_check verification failed");
    end
    $finish;
  end

endmodule

>>> frame_deframer_crc16_check.f
sv/fdcrc_pkg.sv
sv/fdcrc_cfg.sv
sv/frame_deframer_crc16_check.sv
tb/sv/tb_frame_deframer_crc16_check.sv
